@@ hdl/cjss_pkg.sv @@
// Package for the CPU job schedule simulator: widths, policy codes, FSM states.
// No dependencies.
package cjss_pkg;
    localparam int MaxJobs  = 16;
    localparam int TimeBits = 16;
    localparam int OutBits  = 21;
    localparam int NumBits  = 5;
    localparam int PrioBits = 8;
    localparam int CfgAddrBits = 1;
    localparam int CfgDataBits = 16;

    typedef enum logic [1:0] {
        POL_FCFS = 2'd0,
        POL_SRTF = 2'd1,
        POL_PRIO = 2'd2,
        POL_RR   = 2'd3
    } t_policy;

    localparam logic [CfgAddrBits-1:0] REG_MODE    = 1'b0;
    localparam logic [CfgAddrBits-1:0] REG_QUANTUM = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT,
        ST_INIT,
        ST_ADMIT,
        ST_PICK,
        ST_RUN,
        ST_REMOVE,
        ST_EMIT
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic load;
        logic sort_step;
        logic init;
        logic admit_step;
        logic pick_step;
        logic run;
        logic remove_step;
        logic emit_step;
        logic clear;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic sort_done;
        logic admit_done;
        logic queue_empty;
        logic pick_done;
        logic finished;
        logic remove_done;
        logic emit_done;
    } t_status;
endpackage

@@ hdl/cjss_stream_if.sv @@
// Valid/ready channel carrying one word of type T.
// Depends on nothing.
interface cjss_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/cjss_ctrl.sv @@
// Sequencer for load, sort, simulation and result phases.
// Depends on cjss_pkg.
module cjss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  logic              i_out_ready,
    input  cjss_pkg::t_status i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output cjss_pkg::t_cmd    o_cmd
);
    cjss_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cjss_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cjss_pkg::ST_LOAD:
                if (i_in_valid && i_in_last) n_state = cjss_pkg::ST_SORT;
            cjss_pkg::ST_SORT:
                if (i_status.sort_done) n_state = cjss_pkg::ST_INIT;
            cjss_pkg::ST_INIT:
                n_state = cjss_pkg::ST_ADMIT;
            cjss_pkg::ST_ADMIT: begin
                if (i_status.admit_done) begin
                    if (i_status.finished) n_state = cjss_pkg::ST_EMIT;
                    else if (!i_status.queue_empty) n_state = cjss_pkg::ST_PICK;
                end
            end
            cjss_pkg::ST_PICK:
                if (i_status.pick_done) n_state = cjss_pkg::ST_RUN;
            cjss_pkg::ST_RUN:
                n_state = cjss_pkg::ST_REMOVE;
            cjss_pkg::ST_REMOVE:
                if (i_status.remove_done) n_state = cjss_pkg::ST_ADMIT;
            cjss_pkg::ST_EMIT:
                if (i_out_ready && i_status.emit_done) n_state = cjss_pkg::ST_LOAD;
            default: n_state = cjss_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            cjss_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            cjss_pkg::ST_SORT:   o_cmd.sort_step = 1'b1;
            cjss_pkg::ST_INIT:   o_cmd.init = 1'b1;
            cjss_pkg::ST_ADMIT:  o_cmd.admit_step = 1'b1;
            cjss_pkg::ST_PICK:   o_cmd.pick_step = 1'b1;
            cjss_pkg::ST_RUN:    o_cmd.run = 1'b1;
            cjss_pkg::ST_REMOVE: o_cmd.remove_step = 1'b1;
            cjss_pkg::ST_EMIT: begin
                o_out_valid   = 1'b1;
                o_cmd.emit_step = i_out_ready;
                o_cmd.clear   = i_out_ready && i_status.emit_done;
            end
            default: ;
        endcase
    end
endmodule

@@ hdl/cjss_datapath.sv @@
// Job tables, arrival sort, ready queue and tick arithmetic.
// Depends on cjss_pkg.
module cjss_datapath #(
    parameter int MAX_JOBS  = cjss_pkg::MaxJobs,
    parameter int TIME_BITS = cjss_pkg::TimeBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cjss_pkg::t_cmd                i_cmd,
    input  logic [1:0]                    i_mode,
    input  logic [15:0]                   i_quantum,
    input  logic [TIME_BITS-1:0]          i_arrival,
    input  logic [TIME_BITS-1:0]          i_burst,
    input  logic [cjss_pkg::PrioBits-1:0] i_prio,
    output cjss_pkg::t_status             o_status,
    output logic [cjss_pkg::NumBits-1:0]  o_job_number,
    output logic [cjss_pkg::OutBits-1:0]  o_completion,
    output logic [cjss_pkg::OutBits-1:0]  o_turnaround,
    output logic [cjss_pkg::OutBits-1:0]  o_waiting,
    output logic                          o_last
);
    localparam int IdxBits = $clog2(MAX_JOBS);
    localparam int CntBits = $clog2(MAX_JOBS + 1);
    localparam int TickBits = TIME_BITS + 6;
    localparam int OB = cjss_pkg::OutBits;

    typedef logic [IdxBits-1:0] t_idx;
    typedef logic [CntBits-1:0] t_cnt;

    logic [TIME_BITS-1:0]          r_arr [MAX_JOBS];
    logic [TIME_BITS-1:0]          r_bur [MAX_JOBS];
    logic [TIME_BITS-1:0]          r_rem [MAX_JOBS];
    logic [cjss_pkg::PrioBits-1:0] r_pri [MAX_JOBS];
    logic [TickBits-1:0]           r_cmp [MAX_JOBS];
    t_idx                          r_ord [MAX_JOBS];
    t_idx                          r_rq  [MAX_JOBS];

    t_cnt r_jobs, r_ready, r_next, r_done, r_k, r_m, r_emit, r_slot, r_best;
    logic [TickBits-1:0] r_tick;
    logic                r_held_v, r_sort_ins;
    t_idx                r_held, r_v;
    logic                r_jumped;

    logic [16:0] w_q;
    assign w_q = (i_quantum == '0) ? 17'd1 : {1'b0, i_quantum};

    // arrival of next job in order
    t_idx                w_nj;
    logic [TickBits-1:0] w_narr;
    logic                w_has_next;
    assign w_nj = r_ord[r_next[IdxBits-1:0]];
    assign w_narr = TickBits'(r_arr[w_nj]);
    assign w_has_next = r_next < r_jobs;

    // run computation for the picked job
    t_idx                w_pj;
    logic [TickBits-1:0] w_rem, w_run, w_gap;
    assign w_pj  = r_rq[r_best[IdxBits-1:0]];
    assign w_rem = TickBits'(r_rem[w_pj]);
    assign w_gap = w_narr - r_tick;
    always_comb begin
        w_run = w_rem;
        if (i_mode == cjss_pkg::POL_RR) begin
            if (w_rem > TickBits'(w_q)) w_run = TickBits'(w_q);
        end else if (w_has_next && w_gap < w_rem) begin
            w_run = w_gap;
        end
    end

    // pick comparison of candidate slot r_k against current best
    t_idx w_ca, w_cb;
    logic w_better;
    assign w_ca = r_rq[r_k[IdxBits-1:0]];
    assign w_cb = r_rq[r_best[IdxBits-1:0]];
    always_comb begin
        w_better = 1'b0;
        if (i_mode == cjss_pkg::POL_SRTF) w_better = r_rem[w_ca] < r_rem[w_cb];
        else if (i_mode == cjss_pkg::POL_PRIO) w_better = r_pri[w_ca] < r_pri[w_cb];
    end

    // sort: insertion of job r_k, shifting at position r_m
    logic w_sort_shift;
    assign w_sort_shift = (r_m != '0) &&
        (r_arr[r_ord[r_m[IdxBits-1:0] - 1'b1]] > r_arr[r_v]);

    // emit
    t_idx                w_ej;
    logic [TickBits-1:0] w_ec, w_ea, w_eb, w_ta, w_wt;
    assign w_ej = r_ord[r_emit[IdxBits-1:0]];
    assign w_ec = r_cmp[w_ej];
    assign w_ea = TickBits'(r_arr[w_ej]);
    assign w_eb = TickBits'(r_bur[w_ej]);
    assign w_ta = (w_ec > w_ea) ? w_ec - w_ea : '0;
    assign w_wt = (w_ta > w_eb) ? w_ta - w_eb : '0;
    assign o_job_number = cjss_pkg::NumBits'(w_ej) + 1'b1;
    assign o_completion = w_ec[OB-1:0];
    assign o_turnaround = w_ta[OB-1:0];
    assign o_waiting    = w_wt[OB-1:0];
    assign o_last       = (r_emit + 1'b1) == r_jobs;

    assign o_status.sort_done   = !r_sort_ins && (r_k == r_jobs);
    assign o_status.admit_done  = !(w_has_next && w_narr <= r_tick) && !r_held_v;
    assign o_status.queue_empty = r_ready == '0;
    assign o_status.pick_done   = (r_k >= r_ready) ||
        !(i_mode == cjss_pkg::POL_SRTF || i_mode == cjss_pkg::POL_PRIO);
    assign o_status.finished    = (r_done == r_jobs) ||
        (r_ready == '0 && !w_has_next);
    assign o_status.remove_done = !r_jumped;
    assign o_status.emit_done   = o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jobs <= '0;
            r_ready <= '0;
            r_k <= '0;
            r_sort_ins <= 1'b0;
            r_held_v <= 1'b0;
            r_jumped <= 1'b0;
            r_emit <= '0;
            r_tick <= '0;
        end else begin
            if (i_cmd.load && r_jobs != t_cnt'(MAX_JOBS)) begin
                r_arr[r_jobs[IdxBits-1:0]] <= i_arrival;
                r_bur[r_jobs[IdxBits-1:0]] <= (i_burst == '0) ? TIME_BITS'(1) : i_burst;
                r_pri[r_jobs[IdxBits-1:0]] <= i_prio;
                r_jobs <= r_jobs + 1'b1;
            end
            if (i_cmd.load) begin
                r_k <= '0;
                r_sort_ins <= 1'b0;
            end
            // one insertion-sort shift per cycle
            if (i_cmd.sort_step) begin
                if (!r_sort_ins) begin
                    if (r_k != r_jobs) begin
                        r_v <= r_k[IdxBits-1:0];
                        r_m <= r_k;
                        r_sort_ins <= 1'b1;
                    end
                end else if (w_sort_shift) begin
                    r_ord[r_m[IdxBits-1:0]] <= r_ord[r_m[IdxBits-1:0] - 1'b1];
                    r_m <= r_m - 1'b1;
                end else begin
                    r_ord[r_m[IdxBits-1:0]] <= r_v;
                    r_k <= r_k + 1'b1;
                    r_sort_ins <= 1'b0;
                end
            end
            if (i_cmd.init) begin
                for (int i = 0; i < MAX_JOBS; i++) r_rem[i] <= r_bur[i];
                r_ready <= '0;
                r_next <= '0;
                r_done <= '0;
                r_tick <= '0;
                r_held_v <= 1'b0;
                r_jumped <= 1'b0;
                r_emit <= '0;
            end
            // admit one arrival per cycle, then the held job, then jump idle gaps
            if (i_cmd.admit_step) begin
                r_k <= t_cnt'(1);
                r_best <= '0;
                if (w_has_next && w_narr <= r_tick) begin
                    r_rq[r_ready[IdxBits-1:0]] <= w_nj;
                    r_ready <= r_ready + 1'b1;
                    r_next <= r_next + 1'b1;
                end else if (r_held_v) begin
                    r_rq[r_ready[IdxBits-1:0]] <= r_held;
                    r_ready <= r_ready + 1'b1;
                    r_held_v <= 1'b0;
                end else if (r_ready == '0 && w_has_next && r_done != r_jobs) begin
                    r_tick <= w_narr;
                end
            end
            if (i_cmd.pick_step && r_k < r_ready) begin
                if (w_better) r_best <= r_k;
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.run) begin
                r_rem[w_pj] <= r_rem[w_pj] - w_run[TIME_BITS-1:0];
                r_tick <= r_tick + w_run;
                r_slot <= r_best;
                // drop from the queue on completion, and always in round robin
                r_jumped <= (w_run == w_rem) || (i_mode == cjss_pkg::POL_RR);
                if (w_run == w_rem) begin
                    r_cmp[w_pj] <= r_tick + w_run;
                    r_done <= r_done + 1'b1;
                end else if (i_mode == cjss_pkg::POL_RR) begin
                    r_held <= w_pj;
                    r_held_v <= 1'b1;
                end
            end
            // drop slot r_slot, shifting one entry per cycle
            if (i_cmd.remove_step && r_jumped) begin
                if (r_slot + 1'b1 < r_ready) begin
                    r_rq[r_slot[IdxBits-1:0]] <= r_rq[r_slot[IdxBits-1:0] + 1'b1];
                    r_slot <= r_slot + 1'b1;
                end else begin
                    r_ready <= r_ready - 1'b1;
                    r_jumped <= 1'b0;
                end
            end
            if (i_cmd.emit_step) r_emit <= r_emit + 1'b1;
            if (i_cmd.clear) begin
                r_jobs <= '0;
                r_ready <= '0;
            end
        end
    end
endmodule

@@ hdl/cpu_job_schedule_simulator_unit.sv @@
// Flow: takes one job per input word; after the last word, insertion-sorts the jobs by
// arrival, initialises, then per event admits each arrived job and then the held job (or
// jumps an idle gap), picks (scanning the ready queue in modes 1 and 2), runs, and drops a
// finished or round-robin job by shifting the queue; results follow as n words, one per
// cycle while the output is ready. One job set is handled at a time.
// Reset (synchronous, active low) empties the job set and sets mode 0, quantum 1.
module cpu_job_schedule_simulator_unit #(
    parameter int MAX_JOBS  = cjss_pkg::MaxJobs,
    parameter int TIME_BITS = cjss_pkg::TimeBits
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cjss_pkg::CfgAddrBits-1:0]    i_cfg_index,
    input  logic [cjss_pkg::CfgDataBits-1:0]    i_cfg_data,
    cjss_stream_if.sink                         s_in,
    cjss_stream_if.source                       m_out
);
    logic [1:0]  r_mode;
    logic [15:0] r_quantum;
    cjss_pkg::t_cmd    w_cmd;
    cjss_pkg::t_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= cjss_pkg::POL_FCFS;
            r_quantum <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cjss_pkg::REG_MODE:    r_mode <= i_cfg_data[1:0];
                cjss_pkg::REG_QUANTUM: r_quantum <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cjss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .i_in_last   (s_in.data.last_job),
        .i_out_ready (m_out.ready),
        .i_status    (w_status),
        .o_in_ready  (s_in.ready),
        .o_out_valid (m_out.valid),
        .o_cmd       (w_cmd)
    );

    cjss_datapath #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_mode       (r_mode),
        .i_quantum    (r_quantum),
        .i_arrival    (TIME_BITS'(s_in.data.arrival_time)),
        .i_burst      (TIME_BITS'(s_in.data.burst_time)),
        .i_prio       (s_in.data.job_priority),
        .o_status     (w_status),
        .o_job_number (m_out.data.job_number),
        .o_completion (m_out.data.completion_time),
        .o_turnaround (m_out.data.turnaround_time),
        .o_waiting    (m_out.data.waiting_time),
        .o_last       (m_out.data.last_result)
    );

`ifndef NO_ASSERTIONS
    // input and output never open together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_in.ready && m_out.valid)) else $error("in/out overlap");
    // a run and a load never coincide
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load && w_cmd.run)) else $error("load during run");
    // the final word clears the set
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.ready && m_out.data.last_result) |=> s_in.ready)
        else $error("no return to load");
`endif
endmodule

@@ bench/cpu_job_schedule_simulator_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for cpu_job_schedule_simulator_unit: loads job sets under every policy and
// checks each per-job result against a built-in scheduler predictor.
// Depends on cjss_pkg, cjss_stream_if and cpu_job_schedule_simulator_unit.
module cpu_job_schedule_simulator_unit_tb;

    typedef struct packed {
        logic [cjss_pkg::TimeBits-1:0] arrival_time;
        logic [cjss_pkg::TimeBits-1:0] burst_time;
        logic [cjss_pkg::PrioBits-1:0] job_priority;
        logic                          last_job;
    } t_job_word;

    typedef struct packed {
        logic [cjss_pkg::NumBits-1:0] job_number;
        logic [cjss_pkg::OutBits-1:0] completion_time;
        logic [cjss_pkg::OutBits-1:0] turnaround_time;
        logic [cjss_pkg::OutBits-1:0] waiting_time;
        logic                         last_result;
    } t_job_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [cjss_pkg::CfgAddrBits-1:0] i_cfg_index;
    logic [cjss_pkg::CfgDataBits-1:0] i_cfg_data;

    cjss_stream_if #(.T(t_job_word))   job_if ();
    cjss_stream_if #(.T(t_job_result)) res_if ();

    cpu_job_schedule_simulator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_in        (job_if.sink),
        .m_out       (res_if.source)
    );

    // predictor state
    cjss_pkg::t_policy                sched_mode;
    logic [cjss_pkg::CfgDataBits-1:0] sched_quantum;
    longint                           arr_tab [cjss_pkg::MaxJobs];
    longint                           bst_tab [cjss_pkg::MaxJobs];
    int                               pri_tab [cjss_pkg::MaxJobs];
    int                               loaded_jobs;
    t_job_result                      expected_results [$];
    int                               fail_count;
    bit                               quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Simulate the loaded set and queue one result per job in arrival order.
    function automatic void schedule_set();
        int     order [cjss_pkg::MaxJobs];
        longint rem [cjss_pkg::MaxJobs];
        longint comp [cjss_pkg::MaxJobs];
        int     rq [$];
        int     n, k, m, nxt, done, held, slot, j;
        bit     has_held;
        longint q, tick, run, ta, w;
        t_job_result r;
        n = loaded_jobs;
        for (k = 0; k < n; k++) begin
            m = k;
            while (m > 0 && arr_tab[order[m-1]] > arr_tab[k]) begin
                order[m] = order[m-1];
                m--;
            end
            order[m] = k;
        end
        q = (sched_quantum == 0) ? 1 : sched_quantum;
        for (k = 0; k < n; k++) rem[k] = bst_tab[k];
        nxt = 0; done = 0; held = 0; has_held = 0; tick = 0;
        while (done < n) begin
            while (nxt < n && arr_tab[order[nxt]] <= tick) begin
                rq = {rq, order[nxt]};
                nxt++;
            end
            if (has_held) begin
                rq = {rq, held};
                has_held = 0;
            end
            if (rq.size() == 0) begin
                if (nxt >= n) break;
                tick = arr_tab[order[nxt]];
                continue;
            end
            slot = 0;
            if (sched_mode == cjss_pkg::POL_SRTF || sched_mode == cjss_pkg::POL_PRIO) begin
                for (k = 1; k < rq.size(); k++) begin
                    if (sched_mode == cjss_pkg::POL_SRTF && rem[rq[k]] < rem[rq[slot]])
                        slot = k;
                    else if (sched_mode == cjss_pkg::POL_PRIO &&
                             pri_tab[rq[k]] < pri_tab[rq[slot]])
                        slot = k;
                end
            end
            j = rq[slot];
            run = rem[j];
            if (sched_mode == cjss_pkg::POL_RR) begin
                if (run > q) run = q;
            end else if (nxt < n && arr_tab[order[nxt]] - tick < run) begin
                run = arr_tab[order[nxt]] - tick;
            end
            rem[j] -= run;
            tick += run;
            if (sched_mode == cjss_pkg::POL_RR) begin
                rq.delete(slot);
                if (rem[j] == 0) begin
                    comp[j] = tick;
                    done++;
                end else begin
                    held = j;
                    has_held = 1;
                end
            end else if (rem[j] == 0) begin
                comp[j] = tick;
                rq.delete(slot);
                done++;
            end
        end
        for (k = 0; k < n; k++) begin
            j = order[k];
            ta = (comp[j] > arr_tab[j]) ? comp[j] - arr_tab[j] : 0;
            w = (ta > bst_tab[j]) ? ta - bst_tab[j] : 0;
            r.job_number = cjss_pkg::NumBits'(j + 1);
            r.completion_time = comp[j][cjss_pkg::OutBits-1:0];
            r.turnaround_time = ta[cjss_pkg::OutBits-1:0];
            r.waiting_time = w[cjss_pkg::OutBits-1:0];
            r.last_result = (k + 1 == n);
            expected_results = {expected_results, r};
        end
        loaded_jobs = 0;
    endfunction

    function automatic void accept_job(t_job_word jw);
        if (loaded_jobs < cjss_pkg::MaxJobs) begin
            arr_tab[loaded_jobs] = jw.arrival_time;
            bst_tab[loaded_jobs] = (jw.burst_time == 0) ? 1 : jw.burst_time;
            pri_tab[loaded_jobs] = jw.job_priority;
            loaded_jobs++;
        end
        if (jw.last_job) schedule_set();
    endfunction

    // Send one word; valid stays high on return so back-to-back words need no toggle.
    task automatic send_job(input t_job_word jw);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            job_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        job_if.valid <= 1'b1;
        job_if.data  <= jw;
        do @(posedge i_clk); while (!job_if.ready);
        accept_job(jw);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        job_if.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [cjss_pkg::CfgAddrBits-1:0] idx,
                             input logic [cjss_pkg::CfgDataBits-1:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == cjss_pkg::REG_MODE) sched_mode = cjss_pkg::t_policy'(val[1:0]);
        else sched_quantum = val;
    endtask

    task automatic send_set(input int n, input int max_arr, input int max_burst);
        t_job_word jw;
        for (int k = 0; k < n; k++) begin
            jw.arrival_time = cjss_pkg::TimeBits'($urandom_range(0, max_arr));
            jw.burst_time   = cjss_pkg::TimeBits'($urandom_range(1, max_burst));
            jw.job_priority = cjss_pkg::PrioBits'($urandom_range(0, 255));
            jw.last_job     = (k == n - 1);
            send_job(jw);
        end
    endtask

    // result checker with random backpressure
    initial begin
        int stall;
        t_job_result got, exp_r;
        stall = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %p",
                             $realtime, got);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: result mismatch expected %p actual %p",
                                 $realtime, exp_r, got);
                        fail_count++;
                    end
                end
            end
            @(negedge i_clk);
            if (stall > 0) stall--;
            else if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 16);
            res_if.ready <= (stall == 0) && i_rst_n;
        end
    end

    task automatic test_reset_defaults();
        // mode 0 out of reset
        send_job('{16'd3, 16'd4, 8'd1, 1'b0});
        send_job('{16'd0, 16'd2, 8'd0, 1'b1});
    endtask

    task automatic test_each_policy();
        for (int p = 0; p < 4; p++) begin
            write_reg(cjss_pkg::REG_MODE, 16'(p));
            write_reg(cjss_pkg::REG_QUANTUM, 16'd2);
            // equal arrivals, equal remaining, equal priorities exercise the tie rules
            send_job('{16'd0, 16'd5, 8'd7, 1'b0});
            send_job('{16'd0, 16'd5, 8'd7, 1'b0});
            send_job('{16'd1, 16'd2, 8'd0, 1'b0});
            send_job('{16'd20, 16'd3, 8'd9, 1'b1});
        end
    endtask

    task automatic test_extremes();
        write_reg(cjss_pkg::REG_MODE, 16'(cjss_pkg::POL_FCFS));
        send_job('{16'hFFFF, 16'hFFFF, 8'hFF, 1'b0});
        send_job('{16'h0000, 16'h0000, 8'h00, 1'b1});
        write_reg(cjss_pkg::REG_MODE, 16'(cjss_pkg::POL_PRIO));
        send_job('{16'h0000, 16'hFFFF, 8'hFF, 1'b0});
        send_job('{16'h8000, 16'h0001, 8'h00, 1'b1});
        write_reg(cjss_pkg::REG_MODE, 16'(cjss_pkg::POL_RR));
        write_reg(cjss_pkg::REG_QUANTUM, 16'hFFFF);
        send_job('{16'h0005, 16'hFFFF, 8'h55, 1'b0});
        send_job('{16'h0005, 16'hAAAA, 8'hAA, 1'b1});
        // zero quantum serves as one tick
        write_reg(cjss_pkg::REG_QUANTUM, 16'h0000);
        send_job('{16'h0000, 16'h0003, 8'h01, 1'b0});
        send_job('{16'h0001, 16'h0002, 8'h02, 1'b1});
    endtask

    task automatic test_overflow();
        write_reg(cjss_pkg::REG_MODE, 16'(cjss_pkg::POL_SRTF));
        send_set(18, 40, 30);
    endtask

    task automatic test_random_sets(input int items);
        int sent, n, mode, qv, mb, ma;
        sent = 0;
        while (sent < items) begin
            mode = $urandom_range(0, 3);
            qv = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 8);
            if ($urandom_range(0, 2) == 0) write_reg(cjss_pkg::REG_MODE, 16'(mode));
            if ($urandom_range(0, 2) == 0) write_reg(cjss_pkg::REG_QUANTUM, 16'(qv));
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : $urandom_range(1, 6);
            // keep round robin slice counts bounded
            if (sched_mode == cjss_pkg::POL_RR)
                mb = ((sched_quantum == 0 ? 1 : sched_quantum) * 40 > 65535) ? 65535 :
                     (sched_quantum == 0 ? 1 : sched_quantum) * 40;
            else
                mb = ($urandom_range(0, 3) == 0) ? 65535 : 30;
            ma = ($urandom_range(0, 3) == 0) ? 65535 : 50;
            send_set(n, ma, mb);
            sent += n;
        end
    endtask

    initial begin
        fail_count    = 0;
        quiet         = 0;
        loaded_jobs   = 0;
        sched_mode    = cjss_pkg::POL_FCFS;
        sched_quantum = 1;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        job_if.valid  = 1'b0;
        job_if.data   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_each_policy();
        test_extremes();
        test_overflow();
        test_random_sets(260);
        wait_idle();
        quiet = 1;
        test_random_sets(60);
        wait_idle();
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/cjss_pkg.sv
hdl/cjss_stream_if.sv
hdl/cjss_ctrl.sv
hdl/cjss_datapath.sv
hdl/cpu_job_schedule_simulator_unit.sv
bench/cpu_job_schedule_simulator_unit_tb.sv
